[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker module of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define UCT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define UCT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/uct_pkg.sv]
// Package for the URL component tokenizer: codes, character constants,
// and the fixed scheme prefix. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uct_pkg;

    localparam int unsigned PREFIX_LEN = 9;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned COUNT_OUT_W = 5;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        COMP_ROUTE = 2'd0,
        COMP_GEO   = 2'd1,
        COMP_RES   = 2'd2,
        COMP_QUERY = 2'd3
    } t_component;

    typedef enum logic [2:0] {
        CLOSE_NONE  = 3'd0,
        CLOSE_ROUTE = 3'd1,
        CLOSE_GEO   = 3'd2,
        CLOSE_RES   = 3'd3,
        CLOSE_QUERY = 3'd4
    } t_closed;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_PREFIX = 2'd1,
        ST_SHORT  = 2'd2
    } t_status;

    // Expected byte of the scheme prefix "spring://" at a given position.
    function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        begin
            unique case (pos)
                4'd0:    c = 8'h73; // s
                4'd1:    c = 8'h70; // p
                4'd2:    c = 8'h72; // r
                4'd3:    c = 8'h69; // i
                4'd4:    c = 8'h6E; // n
                4'd5:    c = 8'h67; // g
                4'd6:    c = 8'h3A; // :
                4'd7:    c = 8'h2F; // /
                4'd8:    c = 8'h2F; // /
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Token code that closing the given component reports.
    function automatic t_closed close_code(input t_component comp);
        t_closed c;
        begin
            unique case (comp)
                COMP_ROUTE: c = CLOSE_ROUTE;
                COMP_GEO:   c = CLOSE_GEO;
                COMP_RES:   c = CLOSE_RES;
                COMP_QUERY: c = CLOSE_QUERY;
                default:    c = CLOSE_NONE;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/url_component_tokenizer_unit.sv]
// URL component tokenizer, top level: prefix check, component tracking,
// segment counting and the output register. Depends on uct_pkg.
//
// Usage: the slave stream carries one URL byte per transfer in tdata; a
// transfer with tlast high is the terminator after the URL's last byte
// (its tdata is ignored). Every input transfer yields exactly one result
// transfer on the master stream, which carries the byte, the append flag,
// the closed token, the component, the route-segment count and the status;
// tlast marks the result of the terminator.
// The state update and the result are computed in the cycle of acceptance
// and the result is registered and presented in the next cycle.
// Throughput is one byte per clock; the single result register is refilled
// in the cycle it is emptied, so the only thing that slows the block is
// the receiver. When the receiver stalls, the result is held and the input
// is refused once the result register is full.
// Reset (synchronous, active low) empties the result register and starts
// a new URL; a terminator also returns all tracking state to that start.
`timescale 1ns / 1ps
`default_nettype none

module url_component_tokenizer_unit
    import uct_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  wire logic        i_s_axis_tlast,   // is_end
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] char_out, [8] append, [11:9] closed_into, [13:12] component,
    // [18:14] route_count, [20:19] status, [23:21] zero
    output      logic [23:0] o_m_axis_tdata,
    output      logic        o_m_axis_tlast    // url_end
);

    localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

    // Tracking state.
    logic [POS_W-1:0] r_prefix_pos, n_prefix_pos;
    t_component       r_comp, n_comp;
    t_status          r_err, n_err;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_body_seen, n_body_seen;

    // Result register.
    logic             r_out_valid;
    logic [7:0]       r_char, n_char;
    logic             r_append, n_append;
    t_closed          r_closed, n_closed;
    t_component       r_res_comp, n_res_comp;
    logic [COUNT_OUT_W-1:0] r_res_cnt, n_res_cnt;
    t_status          r_status, n_status;
    logic             r_url_end;

    logic             s_accept;
    logic             prefix_done;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] step_cnt;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign prefix_done     = (r_prefix_pos == POS_W'(PREFIX_LEN));
    assign cnt_inc         = (r_cnt < CNT_MAX) ? r_cnt + 1'b1 : r_cnt;

    always_comb begin
        n_prefix_pos = r_prefix_pos;
        n_comp       = r_comp;
        n_err        = r_err;
        n_body_seen  = r_body_seen;
        step_cnt     = r_cnt;
        n_char       = 8'h00;
        n_append     = 1'b0;
        n_closed     = CLOSE_NONE;
        n_status     = r_err;

        if (i_s_axis_tlast) begin
            if (!prefix_done || !r_body_seen) begin
                n_status = ST_SHORT;
            end else begin
                n_closed = close_code(r_comp);
                if (r_comp == COMP_ROUTE) begin
                    step_cnt = cnt_inc;
                end
            end
        end else begin
            n_char = i_s_axis_tdata;
            if (!prefix_done) begin
                if (i_s_axis_tdata != prefix_char(r_prefix_pos)) begin
                    n_err = ST_PREFIX;
                end
                n_prefix_pos = r_prefix_pos + 1'b1;
            end else begin
                n_body_seen = 1'b1;
                unique case (i_s_axis_tdata)
                    CH_DOT: begin
                        step_cnt = cnt_inc;
                        n_closed = CLOSE_ROUTE;
                    end
                    CH_COLON: begin
                        // A colon closes a route segment in any component.
                        step_cnt = cnt_inc;
                        n_closed = CLOSE_ROUTE;
                        n_comp   = COMP_GEO;
                    end
                    CH_SLASH: begin
                        if (r_comp == COMP_ROUTE || r_comp == COMP_GEO) begin
                            n_closed = close_code(r_comp);
                            if (r_comp == COMP_ROUTE) begin
                                step_cnt = cnt_inc;
                            end
                        end
                        n_comp = COMP_RES;
                    end
                    CH_QUEST: begin
                        if (r_comp != COMP_QUERY) begin
                            n_closed = close_code(r_comp);
                            if (r_comp == COMP_ROUTE) begin
                                step_cnt = cnt_inc;
                            end
                        end
                        n_comp = COMP_QUERY;
                    end
                    CH_NUL: begin
                        n_closed = close_code(r_comp);
                        if (r_comp == COMP_ROUTE) begin
                            step_cnt = cnt_inc;
                        end
                    end
                    default: begin
                        n_append = 1'b1;
                    end
                endcase
            end
            n_status = n_err;
        end

        n_res_comp = n_comp;
        n_res_cnt  = COUNT_OUT_W'(step_cnt);
        n_cnt      = step_cnt;

        // The terminator reports its result, then a new URL starts.
        if (i_s_axis_tlast) begin
            n_prefix_pos = '0;
            n_comp       = COMP_ROUTE;
            n_err        = ST_OK;
            n_cnt        = '0;
            n_body_seen  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_pos <= '0;
            r_comp       <= COMP_ROUTE;
            r_err        <= ST_OK;
            r_cnt        <= '0;
            r_body_seen  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_accept) begin
                r_prefix_pos <= n_prefix_pos;
                r_comp       <= n_comp;
                r_err        <= n_err;
                r_cnt        <= n_cnt;
                r_body_seen  <= n_body_seen;
                r_out_valid  <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_char     <= n_char;
            r_append   <= n_append;
            r_closed   <= n_closed;
            r_res_comp <= n_res_comp;
            r_res_cnt  <= n_res_cnt;
            r_status   <= n_status;
            r_url_end  <= i_s_axis_tlast;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_url_end;
    assign o_m_axis_tdata  = {3'b000, r_status, r_res_cnt, r_res_comp, r_closed,
                              r_append, r_char};

endmodule

`default_nettype wire

[hw/rtl/uct_checker.sv]
// Port-level checker for the URL component tokenizer, bound to the top level.
// Depends on uct_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module uct_checker
    import uct_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);

    logic    res_append;
    t_closed res_closed;
    t_status res_status;

    assign res_append = o_m_axis_tdata[8];
    assign res_closed = t_closed'(o_m_axis_tdata[11:9]);
    assign res_status = t_status'(o_m_axis_tdata[20:19]);

    // Nothing is presented in the cycle after reset.
    `UCT_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> !o_m_axis_tvalid,
        "result valid after reset")

    // A stalled result stays put until it is taken.
    `UCT_ASSERT(a_hold_on_stall, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast),
        "stalled result changed")

    // An appended byte never closes a token and is never the terminator.
    `UCT_ASSERT(a_append_excl, i_clk, i_rst_n,
        o_m_axis_tvalid && res_append |-> res_closed == CLOSE_NONE && !o_m_axis_tlast,
        "append with close or end")

    // A short URL closes nothing and only the terminator reports it.
    `UCT_ASSERT(a_short_at_end, i_clk, i_rst_n,
        o_m_axis_tvalid && res_status == ST_SHORT |-> o_m_axis_tlast && res_closed == CLOSE_NONE,
        "short status misplaced")

    // The terminator result carries no byte.
    `UCT_ASSERT(a_end_no_byte, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tdata[7:0] == 8'h00 && !res_append,
        "terminator carries a byte")

endmodule

bind url_component_tokenizer_unit uct_checker u_uct_checker (.*);

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for url_component_tokenizer_unit: a directed table, then
// random URL streams under several idle and stall patterns, each checked by a predictor.
// Depends on uct_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import uct_pkg::*;

    localparam int unsigned SEG_LIMIT = 16;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam logic [8*9-1:0] SCHEME = "spring://";
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_FF = 8'hFF;

    typedef struct {
        logic [7:0] ch;
        logic       append;
        t_closed    closed;
        t_component comp;
        logic [4:0] count;
        t_status    status;
        logic       url_end;
    } t_url_tag;

    // One row of the directed table; the e_ fields are used only where typed is set.
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic [7:0] e_ch;
        logic       e_app;
        logic [2:0] e_closed;
        logic [1:0] e_comp;
        logic [4:0] e_count;
        logic [1:0] e_status;
        logic       e_end;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] ch
    logic        i_s_axis_tlast = 1'b0;    // is_end
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [7:0] char_out, [8] append, [11:9] closed_into, [13:12] component,
    // [18:14] route_count, [20:19] status, [23:21] zero
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;           // url_end

    // Predictor state, reset values as after the block's reset.
    logic [3:0]  pfx_pos = 4'd0;
    t_component  cur_comp = COMP_ROUTE;
    t_status     err_status = ST_OK;
    logic [4:0]  seg_count = 5'd0;
    logic        body_seen = 1'b0;

    t_url_tag    expected_tags[$];
    t_url_tag    due_tag;
    t_url_tag    no_tag;
    int          mismatches = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_req = 1'b0;
    int          hold_left = 0;

    t_dir_row directed_rows [0:21] = '{
        // Terminator right after reset: short URL, nothing closed.
        '{ch: 8'h00, last: 1'b1, typed: 1'b1, e_closed: CLOSE_NONE, e_comp: COMP_ROUTE,
          e_status: ST_SHORT, e_end: 1'b1, default: '0},
        '{ch: 8'h73, default: '0}, '{ch: 8'h70, default: '0}, '{ch: 8'h72, default: '0},
        '{ch: 8'h69, default: '0}, '{ch: 8'h6E, default: '0}, '{ch: 8'h67, default: '0},
        '{ch: CH_COLON, default: '0}, '{ch: CH_SLASH, default: '0},
        '{ch: CH_SLASH, default: '0},
        '{ch: CH_A, default: '0},
        '{ch: CH_DOT, default: '0},
        '{ch: CH_COLON, default: '0},
        '{ch: CH_SLASH, default: '0},
        '{ch: CH_SLASH, default: '0},      // resource: closes nothing
        '{ch: CH_QUEST, default: '0},
        '{ch: CH_QUEST, default: '0},      // query: closes nothing
        '{ch: CH_NUL, default: '0},        // zero byte inside the URL
        '{ch: CH_FF, default: '0},
        '{ch: CH_FF, last: 1'b1, default: '0},
        // Wrong first prefix byte, then a terminator that is still too short.
        '{ch: CH_FF, last: 1'b0, typed: 1'b1, e_ch: CH_FF, e_closed: CLOSE_NONE,
          e_comp: COMP_ROUTE, e_status: ST_PREFIX, default: '0},
        '{ch: 8'hAA, last: 1'b1, typed: 1'b1, e_closed: CLOSE_NONE, e_comp: COMP_ROUTE,
          e_status: ST_SHORT, e_end: 1'b1, default: '0}
    };

    url_component_tokenizer_unit #(
        .MAX_SEGMENTS(SEG_LIMIT)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] scheme_char(input int idx);
        return SCHEME[8*(8-idx) +: 8];
    endfunction

    function automatic void bump_route();
        if (seg_count < SEG_LIMIT)
            seg_count = seg_count + 5'd1;
    endfunction

    function automatic t_closed close_token();
        t_closed c;
        case (cur_comp)
            COMP_ROUTE: begin
                bump_route();
                c = CLOSE_ROUTE;
            end
            COMP_GEO:   c = CLOSE_GEO;
            COMP_RES:   c = CLOSE_RES;
            default:    c = CLOSE_QUERY;
        endcase
        return c;
    endfunction

    // Advances the tracking state by one byte or terminator and returns its tag.
    function automatic t_url_tag tokenize_byte(input logic [7:0] ch, input logic last);
        t_url_tag r;
        r.ch = 8'h00;
        r.append = 1'b0;
        r.closed = CLOSE_NONE;
        r.url_end = last;
        if (last) begin
            if (pfx_pos < PREFIX_LEN || !body_seen) begin
                r.status = ST_SHORT;
            end else begin
                r.closed = close_token();
                r.status = err_status;
            end
        end else begin
            r.ch = ch;
            if (pfx_pos < PREFIX_LEN) begin
                if (ch != scheme_char(int'(pfx_pos)))
                    err_status = ST_PREFIX;
                pfx_pos = pfx_pos + 4'd1;
            end else begin
                body_seen = 1'b1;
                case (ch)
                    CH_DOT: begin
                        bump_route();
                        r.closed = CLOSE_ROUTE;
                    end
                    CH_COLON: begin
                        bump_route();
                        r.closed = CLOSE_ROUTE;
                        cur_comp = COMP_GEO;
                    end
                    CH_SLASH: begin
                        if (cur_comp == COMP_ROUTE || cur_comp == COMP_GEO)
                            r.closed = close_token();
                        cur_comp = COMP_RES;
                    end
                    CH_QUEST: begin
                        if (cur_comp != COMP_QUERY)
                            r.closed = close_token();
                        cur_comp = COMP_QUERY;
                    end
                    CH_NUL:  r.closed = close_token();
                    default: r.append = 1'b1;
                endcase
            end
            r.status = err_status;
        end
        r.comp = cur_comp;
        r.count = seg_count;
        if (last) begin
            pfx_pos = 4'd0;
            cur_comp = COMP_ROUTE;
            err_status = ST_OK;
            seg_count = 5'd0;
            body_seen = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
    endtask

    // Offers one item and waits for its transfer; the predictor runs on acceptance.
    task automatic send_item(input logic [7:0] ch, input logic last, input logic typed,
                             input t_url_tag typed_tag);
        t_url_tag p;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= ch;
        i_s_axis_tlast <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        p = tokenize_byte(ch, last);
        if (typed)
            p = typed_tag;
        expected_tags.insert(expected_tags.size(), p);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_tags.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed URLs with random bodies; some truncated ones and raw noise.
    task automatic run_urls(input int target);
        int kind;
        int len;
        int bad_pos;
        int r;
        logic bad;
        logic long_body;
        logic [7:0] c;
        while (items_sent < target) begin
            kind = $urandom_range(0, 19);
            if (kind <= 15) begin
                bad = ($urandom_range(0, 7) == 0);
                bad_pos = $urandom_range(0, 8);
                for (int i = 0; i < 9; i++) begin
                    c = scheme_char(i);
                    if (bad && i == bad_pos)
                        c = c ^ (8'h01 << $urandom_range(0, 7));
                    send_item(c, 1'b0, 1'b0, no_tag);
                end
                long_body = ($urandom_range(0, 9) == 0);
                len = long_body ? $urandom_range(20, 60) : $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    // Long bodies lean on route delimiters so the count saturates.
                    r = $urandom_range(0, long_body ? 5 : 11);
                    case (r)
                        0:       c = CH_DOT;
                        1:       c = CH_COLON;
                        2:       c = CH_SLASH;
                        3:       c = CH_QUEST;
                        4:       c = CH_NUL;
                        default: c = 8'($urandom_range(0, 255));
                    endcase
                    send_item(c, 1'b0, 1'b0, no_tag);
                end
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, no_tag);
            end else if (kind == 16) begin
                len = $urandom_range(0, 9);
                for (int i = 0; i < len; i++)
                    send_item(scheme_char(i), 1'b0, 1'b0, no_tag);
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, no_tag);
            end else begin
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                              1'b0, no_tag);
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_tags.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", 32'h0,
                                32'(o_m_axis_tdata));
            end else begin
                due_tag = expected_tags.pop_front();
                if (o_m_axis_tdata[7:0] !== due_tag.ch)
                    report_mismatch("char_out", 32'(due_tag.ch), 32'(o_m_axis_tdata[7:0]));
                if (o_m_axis_tdata[8] !== due_tag.append)
                    report_mismatch("append", 32'(due_tag.append), 32'(o_m_axis_tdata[8]));
                if (o_m_axis_tdata[11:9] !== due_tag.closed)
                    report_mismatch("closed_into", 32'(due_tag.closed),
                                    32'(o_m_axis_tdata[11:9]));
                if (o_m_axis_tdata[13:12] !== due_tag.comp)
                    report_mismatch("component", 32'(due_tag.comp),
                                    32'(o_m_axis_tdata[13:12]));
                if (o_m_axis_tdata[18:14] !== due_tag.count)
                    report_mismatch("route_count", 32'(due_tag.count),
                                    32'(o_m_axis_tdata[18:14]));
                if (o_m_axis_tdata[20:19] !== due_tag.status)
                    report_mismatch("status", 32'(due_tag.status),
                                    32'(o_m_axis_tdata[20:19]));
                if (o_m_axis_tdata[23:21] !== 3'b000)
                    report_mismatch("tdata padding", 32'h0, 32'(o_m_axis_tdata[23:21]));
                if (o_m_axis_tlast !== due_tag.url_end)
                    report_mismatch("url_end", 32'(due_tag.url_end), 32'(o_m_axis_tlast));
            end
        end
    end

    initial begin : main_seq
        t_url_tag tv;
        int base;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            tv.ch = directed_rows[i].e_ch;
            tv.append = directed_rows[i].e_app;
            tv.closed = t_closed'(directed_rows[i].e_closed);
            tv.comp = t_component'(directed_rows[i].e_comp);
            tv.count = directed_rows[i].e_count;
            tv.status = t_status'(directed_rows[i].e_status);
            tv.url_end = directed_rows[i].e_end;
            send_item(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed, tv);
        end
        wait_drained();

        // No idling; the receiver holds off long enough for the input to back up.
        base = items_sent;
        hold_req = 1'b1;
        run_urls(base + RANDOM_ITEMS / 4);
        wait_drained();

        send_idle_pct = 48;
        recv_stall_pct = 0;
        run_urls(base + RANDOM_ITEMS / 2);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 48;
        run_urls(base + 3 * RANDOM_ITEMS / 4);
        wait_drained();

        send_idle_pct = 14;
        recv_stall_pct = 14;
        run_urls(base + RANDOM_ITEMS);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_tags.size() == 0)
            $display("url_component_tokenizer_unit: match");
        else
            $display("url_component_tokenizer_unit: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #8_000_000;
        $display("url_component_tokenizer_unit: mismatch");
        $finish;
    end

endmodule
